// ----- rtl/core/fptt_pkg.sv -----
// Shared widths, register codes, types and helpers for the page-table translator.
package fptt_pkg;

    localparam int VADDR_W      = 24;
    localparam int PADDR_W      = 22;
    localparam int PAGE_BYTES_W = 17;
    localparam int PAGES_W      = 9;
    localparam int FRAMES_W     = 7;
    localparam int EVPAGE_W     = 8;
    localparam int PAGE_IDX_W   = 12;
    localparam int CFG_IDX_W    = 2;
    localparam int QUEUE_DEPTH  = 2;

    localparam int MAX_PAGES_DEF  = 256;
    localparam int MAX_FRAMES_DEF = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BYTES    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 2'd2;

    localparam logic [PAGE_BYTES_W-1:0] PAGE_BYTES_RST    = 17'd1024;
    localparam logic [PAGES_W-1:0]      PAGES_IN_USE_RST  = 9'd8;
    localparam logic [FRAMES_W-1:0]     FRAMES_IN_USE_RST = 7'd4;

    typedef struct packed {
        logic [PAGE_BYTES_W-1:0] page_bytes;
        logic [PAGES_W-1:0]      pages_in_use;
        logic [FRAMES_W-1:0]     frames_in_use;
    } cfg_t;

    // one classified access waiting for the table stage
    typedef struct packed {
        logic                    out_of_range;
        logic [PAGE_IDX_W-1:0]   page;
        logic [PAGE_BYTES_W-1:0] offset;
    } queue_item_t;

    // a page size of zero behaves as one byte
    function automatic logic [PAGE_BYTES_W-1:0] eff_page_bytes(
        input logic [PAGE_BYTES_W-1:0] raw);
        logic [PAGE_BYTES_W-1:0] res;
        res = (raw == '0) ? PAGE_BYTES_W'(1) : raw;
        return res;
    endfunction

endpackage

// ----- rtl/core/fifo_page_table_translator_unit.sv -----
// Top level of the page-table translator with FIFO frame replacement.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-------------------------------------------
//  request   | start, busy           | virtual_addr
//  result    | result_valid (strobe) | physical_addr, page_fault, evicted,
//            |                       | evicted_page, out_of_range
//  config    | cfg_valid, cfg_ready  | cfg_index, cfg_data
//
// An item passes through the front divider (one quotient bit a cycle), is handed
// to the queue, then passes through the table stage (read, update, multiply,
// result), which raises the result strobe. busy drops once the item is in the
// queue, so the next item can be accepted while the table stage works; when items
// follow each other, the divider sets the rate.
// After reset the table stage clears its valid and occupancy stores, one entry a
// cycle; busy is high then. Results are shown for one cycle and cannot be held
// off; the two-entry queue lets the divider start the next item while the table
// stage is working.
module fifo_page_table_translator_unit #(
    parameter int MAX_PAGES  = fptt_pkg::MAX_PAGES_DEF,
    parameter int MAX_FRAMES = fptt_pkg::MAX_FRAMES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [fptt_pkg::VADDR_W-1:0]       virtual_addr,
    output logic                               result_valid,
    output logic [fptt_pkg::PADDR_W-1:0]       physical_addr,
    output logic                               page_fault,
    output logic                               evicted,
    output logic [fptt_pkg::EVPAGE_W-1:0]      evicted_page,
    output logic                               out_of_range,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fptt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fptt_pkg::PAGE_BYTES_W-1:0]  cfg_data
);
    import fptt_pkg::*;

    cfg_t        cfg_reg, cfg_next;
    logic        front_busy, clearing;
    logic        q_push, q_pop, q_full, q_empty;
    queue_item_t q_item, q_head;

    assign cfg_ready = 1'b1;
    assign busy      = front_busy || clearing;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PAGE_BYTES:    cfg_next.page_bytes    = cfg_data;
                CFG_PAGES_IN_USE:  cfg_next.pages_in_use  = cfg_data[PAGES_W-1:0];
                CFG_FRAMES_IN_USE: cfg_next.frames_in_use = cfg_data[FRAMES_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.page_bytes    <= PAGE_BYTES_RST;
            cfg_reg.pages_in_use  <= PAGES_IN_USE_RST;
            cfg_reg.frames_in_use <= FRAMES_IN_USE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    fptt_front #(
        .MAX_PAGES (MAX_PAGES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .hold         (clearing),
        .virtual_addr (virtual_addr),
        .cfg          (cfg_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (q_item),
        .front_busy   (front_busy)
    );

    fptt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .pop       (q_pop),
        .head_item (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    fptt_back #(
        .MAX_PAGES  (MAX_PAGES),
        .MAX_FRAMES (MAX_FRAMES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .clearing      (clearing),
        .result_valid  (result_valid),
        .physical_addr (physical_addr),
        .page_fault    (page_fault),
        .evicted       (evicted),
        .evicted_page  (evicted_page),
        .out_of_range  (out_of_range)
    );

endmodule

// ----- rtl/core/fptt_front.sv -----
// Front end: accepts an address, splits it into page and offset, classifies range.
module fptt_front #(
    parameter int MAX_PAGES = fptt_pkg::MAX_PAGES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          hold,
    input  logic [fptt_pkg::VADDR_W-1:0]  virtual_addr,
    input  fptt_pkg::cfg_t                cfg,
    input  logic                          q_full,
    output logic                          q_push,
    output fptt_pkg::queue_item_t         q_item,
    output logic                          front_busy
);
    import fptt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;
    localparam int CNT_W = $clog2(VADDR_W + 1);

    logic [1:0]              state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [VADDR_W-1:0]      quo_reg, quo_next;
    logic [PAGE_BYTES_W-1:0] rem_reg, rem_next;
    logic [PAGE_BYTES_W-1:0] div_reg, div_next;

    logic [PAGE_BYTES_W:0]   trial;
    logic                    take;
    logic [VADDR_W-1:0]      npages;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[VADDR_W-1]};
    assign take  = trial >= {1'b0, div_reg};

    assign npages = (PAGES_W'(cfg.pages_in_use) > PAGES_W'(MAX_PAGES) && MAX_PAGES < 512)
                  ? VADDR_W'(MAX_PAGES) : VADDR_W'(cfg.pages_in_use);

    assign front_busy          = state_reg != ST_IDLE;
    assign q_item.out_of_range = quo_reg >= npages;
    assign q_item.page         = PAGE_IDX_W'(quo_reg);
    assign q_item.offset       = rem_reg;
    assign q_push              = (state_reg == ST_PUSH) && !q_full;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && !hold)
                begin
                    quo_next   = virtual_addr;
                    rem_next   = '0;
                    div_next   = eff_page_bytes(cfg.page_bytes);
                    cnt_next   = CNT_W'(VADDR_W);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = take ? PAGE_BYTES_W'(trial - {1'b0, div_reg})
                                : PAGE_BYTES_W'(trial);
                quo_next = {quo_reg[VADDR_W-2:0], take};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                    state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (!q_full)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

endmodule

// ----- rtl/core/fptt_queue.sv -----
// Two-entry queue between the front end and the table stage.
module fptt_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  fptt_pkg::queue_item_t push_item,
    input  logic                  pop,
    output fptt_pkg::queue_item_t head_item,
    output logic                  full,
    output logic                  empty
);
    import fptt_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    queue_item_t      slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty     = count_reg == '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ----- rtl/core/fptt_back.sv -----
// Table stage: page lookup, FIFO frame replacement and address rebuild.
module fptt_back #(
    parameter int MAX_PAGES  = fptt_pkg::MAX_PAGES_DEF,
    parameter int MAX_FRAMES = fptt_pkg::MAX_FRAMES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fptt_pkg::cfg_t                 cfg,
    input  logic                           q_empty,
    input  fptt_pkg::queue_item_t          q_head,
    output logic                           q_pop,
    output logic                           clearing,
    output logic                           result_valid,
    output logic [fptt_pkg::PADDR_W-1:0]   physical_addr,
    output logic                           page_fault,
    output logic                           evicted,
    output logic [fptt_pkg::EVPAGE_W-1:0]  evicted_page,
    output logic                           out_of_range
);
    import fptt_pkg::*;

    localparam int PW    = $clog2(MAX_PAGES);
    localparam int FW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int NFW_A = $clog2(MAX_FRAMES + 1);
    localparam int NFW   = (NFW_A > FRAMES_W) ? NFW_A : FRAMES_W;
    localparam int CLR_N = (MAX_PAGES > MAX_FRAMES) ? MAX_PAGES : MAX_FRAMES;
    localparam int CLRW  = $clog2(CLR_N);
    localparam int PRODW = FW + PAGE_BYTES_W;
    localparam int SUMW  = ((PRODW > PADDR_W) ? PRODW : PADDR_W) + 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RD    = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    // table storage
    logic          page_valid_mem [MAX_PAGES];
    logic [FW-1:0] page_frame_mem [MAX_PAGES];
    logic          frame_occ_mem  [MAX_FRAMES];
    logic [PW-1:0] frame_owner_mem[MAX_FRAMES];

    logic          pv_rdata, fo_rdata;
    logic [FW-1:0] pf_rdata;
    logic [PW-1:0] fw_rdata;

    logic          pv_we, pv_wdata, pf_we, fo_we, fo_wdata, fw_we;
    logic [PW-1:0] pv_waddr;
    logic [FW-1:0] fo_waddr;

    logic [2:0]              state_reg, state_next;
    logic [CLRW-1:0]         clr_reg, clr_next;
    logic [FW-1:0]           ptr_reg, ptr_next;
    logic [PW-1:0]           page_reg, page_next;
    logic [PAGE_BYTES_W-1:0] offset_reg, offset_next;
    logic                    oor_reg, oor_next;
    logic [FW-1:0]           f_reg, f_next;
    logic [FW-1:0]           frame_reg, frame_next;
    logic                    fault_reg, fault_next;
    logic                    ev_reg, ev_next;
    logic [PW-1:0]           evpage_reg, evpage_next;
    logic [PRODW-1:0]        prod_reg, prod_next;

    logic [NFW-1:0]          nframes;
    logic [FW-1:0]           f_sel;
    logic [NFW-1:0]          f_inc;
    logic [PAGE_BYTES_W-1:0] psize;
    logic [SUMW-1:0]         sum;
    logic                    clr_page, clr_frame;

    assign psize   = eff_page_bytes(cfg.page_bytes);
    assign nframes = (cfg.frames_in_use == '0) ? NFW'(1)
                   : (NFW'(cfg.frames_in_use) > NFW'(MAX_FRAMES)) ? NFW'(MAX_FRAMES)
                   : NFW'(cfg.frames_in_use);
    // a pointer left beyond a shrunk frame count restarts at frame 0
    assign f_sel   = (NFW'(ptr_reg) < nframes) ? ptr_reg : '0;
    assign f_inc   = NFW'(f_reg) + NFW'(1);

    assign clr_page  = {1'b0, clr_reg} < (CLRW + 1)'(MAX_PAGES);
    assign clr_frame = {1'b0, clr_reg} < (CLRW + 1)'(MAX_FRAMES);

    assign clearing = state_reg == ST_CLEAR;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;

    always_comb
    begin
        pv_we    = 1'b0;
        pv_waddr = page_reg;
        pv_wdata = 1'b0;
        pf_we    = 1'b0;
        fo_we    = 1'b0;
        fo_waddr = f_reg;
        fo_wdata = 1'b0;
        fw_we    = 1'b0;

        state_next  = state_reg;
        clr_next    = clr_reg;
        ptr_next    = ptr_reg;
        page_next   = page_reg;
        offset_next = offset_reg;
        oor_next    = oor_reg;
        f_next      = f_reg;
        frame_next  = frame_reg;
        fault_next  = fault_reg;
        ev_next     = ev_reg;
        evpage_next = evpage_reg;
        prod_next   = prod_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                pv_we    = clr_page;
                pv_waddr = PW'(clr_reg);
                fo_we    = clr_frame;
                fo_waddr = FW'(clr_reg);
                clr_next = clr_reg + CLRW'(1);
                if (clr_reg == CLRW'(CLR_N - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    page_next   = PW'(q_head.page);
                    offset_next = q_head.offset;
                    oor_next    = q_head.out_of_range;
                    f_next      = f_sel;
                    state_next  = ST_RD;
                end
            end
            ST_RD:
            begin
                fault_next  = 1'b0;
                ev_next     = 1'b0;
                evpage_next = '0;
                frame_next  = '0;
                if (!oor_reg)
                begin
                    if (pv_rdata)
                        frame_next = pf_rdata;
                    else
                    begin
                        frame_next = f_reg;
                        fault_next = 1'b1;
                        if (fo_rdata)
                        begin
                            ev_next     = 1'b1;
                            evpage_next = fw_rdata;
                        end
                        pv_we    = 1'b1;
                        pv_wdata = 1'b1;
                        pf_we    = 1'b1;
                        fo_we    = 1'b1;
                        fo_wdata = 1'b1;
                        fw_we    = 1'b1;
                        ptr_next = (f_inc == nframes) ? '0 : FW'(f_inc);
                    end
                end
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                // the displaced page loses its mapping
                pv_we     = ev_reg;
                pv_waddr  = evpage_reg;
                prod_next = PRODW'(frame_reg) * PRODW'(psize);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg   <= page_next;
        offset_reg <= offset_next;
        oor_reg    <= oor_next;
        f_reg      <= f_next;
        frame_reg  <= frame_next;
        fault_reg  <= fault_next;
        ev_reg     <= ev_next;
        evpage_reg <= evpage_next;
        prod_reg   <= prod_next;
    end

    always_ff @(posedge clk)
    begin
        if (pv_we)
            page_valid_mem[pv_waddr] <= pv_wdata;
        pv_rdata <= page_valid_mem[PW'(q_head.page)];
    end

    always_ff @(posedge clk)
    begin
        if (pf_we)
            page_frame_mem[page_reg] <= f_reg;
        pf_rdata <= page_frame_mem[PW'(q_head.page)];
    end

    always_ff @(posedge clk)
    begin
        if (fo_we)
            frame_occ_mem[fo_waddr] <= fo_wdata;
        fo_rdata <= frame_occ_mem[f_sel];
    end

    always_ff @(posedge clk)
    begin
        if (fw_we)
            frame_owner_mem[f_reg] <= page_reg;
        fw_rdata <= frame_owner_mem[f_sel];
    end

    assign sum           = SUMW'(prod_reg) + SUMW'(offset_reg);
    assign result_valid  = state_reg == ST_OUT;
    assign physical_addr = oor_reg ? '0 : sum[PADDR_W-1:0];
    assign page_fault    = fault_reg;
    assign evicted       = ev_reg;
    assign evicted_page  = EVPAGE_W'(evpage_reg);
    assign out_of_range  = oor_reg;

endmodule

// ----- rtl/core/fptt_checker.sv -----
// Port-level checks on the translator, bound to the top level.
module fptt_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               result_valid,
    input logic [fptt_pkg::PADDR_W-1:0]       physical_addr,
    input logic                               page_fault,
    input logic                               evicted,
    input logic [fptt_pkg::EVPAGE_W-1:0]      evicted_page,
    input logic                               out_of_range
);

    // an out-of-range item carries no translation and touches no table
    a_oor_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && out_of_range |->
            physical_addr == '0 && !page_fault && !evicted && evicted_page == '0)
        else $error("out-of-range item with non-zero fields");

    // an eviction only happens while loading a page
    a_evict_fault: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && evicted |-> page_fault)
        else $error("eviction without page fault");

    a_no_evict_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !evicted |-> evicted_page == '0)
        else $error("evicted page number without eviction");

    // the table stage never shows results on back-to-back cycles
    a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("results on consecutive cycles");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("not busy after accepting an item");

endmodule

bind fifo_page_table_translator_unit fptt_checker u_fptt_checker (.*);

// ----- bench/tb.sv -----
// Self-checking bench for the page-table translator with FIFO frame replacement.
`timescale 1ns / 100ps

module tb;
    import fptt_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 1800;
    localparam int CALM_TAIL      = 1600;
    localparam int MAX_REPORTS    = 40;

    typedef struct packed {
        logic [PADDR_W-1:0]  phys;
        logic                fault;
        logic                evict;
        logic [EVPAGE_W-1:0] victim;
        logic                oor;
    } xlat_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [VADDR_W-1:0]      virtual_addr;
    logic                    result_valid;
    logic [PADDR_W-1:0]      physical_addr;
    logic                    page_fault;
    logic                    evicted;
    logic [EVPAGE_W-1:0]     evicted_page;
    logic                    out_of_range;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [PAGE_BYTES_W-1:0] cfg_data;

    // translator model state
    logic [PAGE_BYTES_W-1:0] cur_page_bytes;
    logic [PAGES_W-1:0]      cur_pages;
    logic [FRAMES_W-1:0]     cur_frames;
    bit                      page_resident [MAX_PAGES_DEF];
    logic [5:0]              page_to_frame [MAX_PAGES_DEF];
    bit                      frame_taken [MAX_FRAMES_DEF];
    logic [EVPAGE_W-1:0]     frame_owner_page [MAX_FRAMES_DEF];
    logic [5:0]              victim_ptr;

    xlat_t pending_xlat[$];
    xlat_t want;
    int unsigned hot_base;

    int n_errors;
    int n_items;
    int n_faults;
    int n_evicts;
    int n_oor;
    int n_reg_writes;
    int n_settings;
    int idle_cycles;

    fifo_page_table_translator_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .virtual_addr  (virtual_addr),
        .result_valid  (result_valid),
        .physical_addr (physical_addr),
        .page_fault    (page_fault),
        .evicted       (evicted),
        .evicted_page  (evicted_page),
        .out_of_range  (out_of_range),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic longint unsigned eff_psize();
        return (cur_page_bytes == '0) ? 1 : longint'(cur_page_bytes);
    endfunction

    function automatic int unsigned eff_npages();
        return (cur_pages > MAX_PAGES_DEF) ? MAX_PAGES_DEF : int'(cur_pages);
    endfunction

    function automatic int unsigned eff_nframes();
        if (cur_frames == '0)
            return 1;
        return (cur_frames > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : int'(cur_frames);
    endfunction

    // translate one address and update page and frame tables
    function automatic xlat_t translate_addr(input logic [VADDR_W-1:0] va);
        xlat_t r;
        longint unsigned psize;
        longint unsigned vpn;
        longint unsigned off;
        longint unsigned prod;
        int unsigned p;
        int unsigned f;
        logic [EVPAGE_W-1:0] old;
        r = '0;
        psize = eff_psize();
        vpn = va / psize;
        off = va % psize;
        n_items++;
        if (vpn >= eff_npages())
        begin
            r.oor = 1'b1;
            n_oor++;
            return r;
        end
        p = 32'(vpn);
        if (!page_resident[p])
        begin
            f = (victim_ptr < eff_nframes()) ? victim_ptr : 0;
            r.fault = 1'b1;
            n_faults++;
            if (frame_taken[f])
            begin
                old = frame_owner_page[f];
                r.evict = 1'b1;
                r.victim = old;
                page_resident[old] = 1'b0;
                n_evicts++;
            end
            page_to_frame[p] = 6'(f);
            page_resident[p] = 1'b1;
            frame_taken[f] = 1'b1;
            frame_owner_page[f] = EVPAGE_W'(p);
            victim_ptr = 6'((f + 1) % eff_nframes());
        end
        prod = longint'(page_to_frame[p]) * psize + off;
        r.phys = prod[PADDR_W-1:0];
        return r;
    endfunction

    // mostly a sliding working set of in-range pages, plus some misses and noise
    function automatic logic [VADDR_W-1:0] pick_addr();
        longint unsigned psize;
        longint unsigned vpn;
        longint unsigned off;
        longint unsigned va;
        int unsigned npages;
        int unsigned r;
        logic [31:0] noise;
        psize = eff_psize();
        npages = eff_npages();
        r = $urandom_range(0, 99);
        noise = $urandom();
        if (r < 10 || npages == 0)
            return noise[VADDR_W-1:0];
        if (r < 18)
            vpn = npages + $urandom_range(0, 3);
        else
        begin
            if ($urandom_range(0, 29) == 0)
                hot_base = $urandom_range(0, npages - 1);
            vpn = (hot_base + $urandom_range(0, eff_nframes() + 1)) % npages;
        end
        case ($urandom_range(0, 7))
            0: off = 0;
            1: off = psize - 1;
            default: off = $urandom() % psize;
        endcase
        va = vpn * psize + off;
        if (va > 64'hFF_FFFF)
            return noise[VADDR_W-1:0];
        return va[VADDR_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        if (n_errors < MAX_REPORTS)
            $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, exp_val);
        n_errors++;
    endtask

    // results cannot be held off, so every strobe is checked straight away
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_xlat.size() == 0)
                report_mismatch("result with nothing pending", 1, 0);
            else
            begin
                want = pending_xlat.pop_front();
                if (physical_addr !== want.phys)
                    report_mismatch("physical_addr", physical_addr, want.phys);
                if (page_fault !== want.fault)
                    report_mismatch("page_fault", page_fault, want.fault);
                if (evicted !== want.evict)
                    report_mismatch("evicted", evicted, want.evict);
                if (evicted_page !== want.victim)
                    report_mismatch("evicted_page", evicted_page, want.victim);
                if (out_of_range !== want.oor)
                    report_mismatch("out_of_range", out_of_range, want.oor);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: errors");
            $finish;
        end
    end

    // start stays high across back-to-back items; only idling here or quiesce lowers it
    task automatic send_item(input logic [VADDR_W-1:0] va, input bit may_idle);
        if (may_idle && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        start <= 1'b1;
        virtual_addr <= va;
        do
            @(posedge clk);
        while (busy);
        pending_xlat.push_back(translate_addr(va));
    endtask

    task automatic quiesce();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_xlat.size() != 0 || busy);
    endtask

    // leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [PAGE_BYTES_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_PAGE_BYTES:    cur_page_bytes = data;
            CFG_PAGES_IN_USE:  cur_pages = data[PAGES_W-1:0];
            CFG_FRAMES_IN_USE: cur_frames = data[FRAMES_W-1:0];
            default: ;
        endcase
        n_reg_writes++;
    endtask

    task automatic set_config(input logic [PAGE_BYTES_W-1:0] pbytes,
                              input logic [PAGE_BYTES_W-1:0] pages,
                              input logic [PAGE_BYTES_W-1:0] frames);
        quiesce();
        write_reg(CFG_PAGE_BYTES, pbytes);
        write_reg(CFG_PAGES_IN_USE, pages);
        write_reg(CFG_FRAMES_IN_USE, frames);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // reset values: 1 KiB pages, 8 pages, 4 frames
    task automatic test_reset_defaults();
        send_item(24'h000000, 1'b1);
        send_item(24'h0003FF, 1'b1);
        send_item(24'h000400, 1'b1);
        send_item(24'h000800, 1'b0);
        send_item(24'h000C00, 1'b0);
        send_item(24'h001000, 1'b1);
        send_item(24'h000000, 1'b1);
        send_item(24'h001FFF, 1'b0);
        send_item(24'h002000, 1'b1);
        send_item(24'hFFFFFF, 1'b1);
    endtask

    task automatic test_register_extremes();
        // no pages at all: everything out of range
        set_config(17'd0, 17'd0, 17'd0);
        send_item(24'h000000, 1'b0);
        send_item(24'hFFFFFF, 1'b0);
        // zero page size acts as one byte, page and frame counts clamp
        set_config(17'd0, 17'd300, 17'd0);
        send_item(24'h0000FF, 1'b1);
        send_item(24'h000100, 1'b1);
        send_item(24'h0000FF, 1'b0);
        quiesce();
        write_reg(CFG_UNUSED, 17'h1FFFF);
        cfg_valid <= 1'b0;
        set_config(17'h1FFFF, 17'd511, 17'd127);
        send_item(24'hFFFFFF, 1'b0);
        send_item(24'h000000, 1'b1);
    endtask

    // shrink the frame count below the pointer; older mappings must still hit
    task automatic test_pointer_wrap();
        set_config(17'd16, 17'd16, 17'd8);
        send_item(24'h000000, 1'b0);
        send_item(24'h000010, 1'b0);
        send_item(24'h000020, 1'b1);
        send_item(24'h000030, 1'b0);
        send_item(24'h000040, 1'b1);
        set_config(17'd16, 17'd16, 17'd3);
        send_item(24'h000050, 1'b0);
        send_item(24'h00001F, 1'b0);
        send_item(24'h000060, 1'b1);
    endtask

    task automatic test_random_phases();
        int sent;
        int phase_len;
        bit idle_on;
        logic [PAGE_BYTES_W-1:0] pbytes;
        logic [PAGE_BYTES_W-1:0] pages;
        logic [PAGE_BYTES_W-1:0] frames;
        sent = 0;
        // largest pages with all frames, so the product overflows 22 bits
        set_config(17'h1FFFF, 17'd256, 17'd64);
        for (int i = 0; i < 120; i++)
            send_item(pick_addr(), 1'b1);
        sent = 120;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: pbytes = 17'd1 << $urandom_range(0, 16);
                4, 5, 6:    pbytes = PAGE_BYTES_W'($urandom_range(1, 4096));
                7:          pbytes = PAGE_BYTES_W'($urandom_range(1, 65536));
                8:          pbytes = PAGE_BYTES_W'($urandom_range(1, 16));
                default:    pbytes = ($urandom_range(0, 1) == 0) ? 17'd0 : 17'h1FFFF;
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: pages = PAGE_BYTES_W'($urandom_range(1, 32));
                6, 7:             pages = PAGE_BYTES_W'($urandom_range(33, 256));
                8:                pages = 17'd256;
                default:          pages = ($urandom_range(0, 3) == 0) ? 17'd0
                                          : PAGE_BYTES_W'($urandom_range(257, 511));
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: frames = PAGE_BYTES_W'($urandom_range(1, 16));
                7, 8:                frames = PAGE_BYTES_W'($urandom_range(17, 64));
                default:             frames = ($urandom_range(0, 3) == 0) ? 17'd0
                                              : PAGE_BYTES_W'($urandom_range(65, 127));
            endcase
            // junk in the unused upper bits must be dropped
            if ($urandom_range(0, 3) == 0)
                pages[PAGE_BYTES_W-1:PAGES_W] = (PAGE_BYTES_W - PAGES_W)'($urandom());
            if ($urandom_range(0, 3) == 0)
                frames[PAGE_BYTES_W-1:FRAMES_W] = (PAGE_BYTES_W - FRAMES_W)'($urandom());
            set_config(pbytes, pages, frames);
            phase_len = $urandom_range(60, 200);
            idle_on = $urandom_range(0, 3) != 0;
            for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++)
            begin
                send_item(pick_addr(), idle_on && sent < CALM_TAIL);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        virtual_addr = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cur_page_bytes = PAGE_BYTES_RST;
        cur_pages = PAGES_IN_USE_RST;
        cur_frames = FRAMES_IN_USE_RST;
        for (int i = 0; i < MAX_PAGES_DEF; i++)
            page_resident[i] = 1'b0;
        for (int i = 0; i < MAX_FRAMES_DEF; i++)
            frame_taken[i] = 1'b0;
        victim_ptr = '0;
        hot_base = 0;
        n_errors = 0;
        n_items = 0;
        n_faults = 0;
        n_evicts = 0;
        n_oor = 0;
        n_reg_writes = 0;
        n_settings = 1;
        idle_cycles = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_pointer_wrap();
        test_random_phases();

        quiesce();
        repeat (40) @(posedge clk);
        $display("summary: %0d translations, %0d faults, %0d evictions, %0d out of range",
                 n_items, n_faults, n_evicts, n_oor);
        $display("summary: %0d register writes over %0d settings", n_reg_writes, n_settings);
        if (n_errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
